### design/planck_band_radiance_core_defines.svh
// Assertion helpers shared by the block's RTL.
`ifndef PLANCK_BAND_RADIANCE_CORE_DEFINES_SVH
`define PLANCK_BAND_RADIANCE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define PBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pbr_pkg.sv
package pbr_pkg;

    localparam int MAX_STEPS = 4096;
    localparam int TERMS_W   = $clog2(MAX_STEPS + 1);

    typedef logic signed [15:0] t_exp;

    typedef struct packed {
        logic [63:0] m;
        t_exp        e;
    } t_ufl;

    typedef enum logic [1:0] {
        MDU_MUL,
        MDU_DIVF,
        MDU_DIVI,
        MDU_NORM
    } t_mdu_op;

    typedef struct packed {
        logic        start;
        t_mdu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_mdu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [6:0]  cnt;
    } t_mdu_rsp;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;
    localparam logic [1:0] CFG_EMIS  = 2'd3;

    localparam logic [23:0] RST_START = 24'd524288;
    localparam logic [23:0] RST_END   = 24'd917504;
    localparam logic [31:0] RST_STEP  = 32'd65536;
    localparam logic [16:0] RST_EMIS  = 17'd65536;

    // 10000 * 2^32, numerator of the wavelength to wavenumber conversion
    localparam logic [63:0] WN_NUM  = 64'd42949672960000;
    localparam logic [32:0] WN_MAX  = 33'h1_FFFF_FFFF;
    // second radiation constant, 6179448269 * 2^-32, normalized
    localparam logic [63:0] C2_M    = 64'd6179448269 << 31;
    localparam t_exp        C2_E    = -16'sd63;
    // first radiation constant, already normalized
    localparam logic [63:0] C1_M    = 64'd14743262263000000000;
    localparam t_exp        C1_E    = -16'sd90;
    localparam logic [63:0] LOG2E   = 64'd6196328019;
    localparam logic [63:0] LN2     = 64'd744261118;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [30:0] X_ONE   = 31'h100_0000;
    localparam logic [30:0] X_MAX   = 31'h4000_0000;
    localparam logic [4:0]  SER_LAST_SMALL = 5'd21;
    localparam logic [4:0]  SER_LAST_BIG   = 5'd20;

    // upper half of a normalized mantissa product
    function automatic t_ufl fmul_norm(logic [63:0] hi, logic [63:0] lo, t_exp esum);
        t_ufl r;
        if (hi[63]) begin
            r.m = hi;
            r.e = esum + 16'sd64;
        end else begin
            r.m = {hi[62:0], lo[63]};
            r.e = esum + 16'sd63;
        end
        return r;
    endfunction

    // quotient of two normalized mantissas is at least 2^62
    function automatic t_ufl fdiv_norm(logic [63:0] q, t_exp e0);
        t_ufl r;
        if (q[63]) begin
            r.m = q;
            r.e = e0;
        end else begin
            r.m = {q[62:0], 1'b0};
            r.e = e0 - 16'sd1;
        end
        return r;
    endfunction

    // to fixed point with frac fraction bits; top bit flags overflow
    function automatic logic [64:0] fix_q(t_ufl a, t_exp frac);
        t_exp        s;
        t_exp        ns;
        logic [64:0] r;
        s  = a.e + frac;
        ns = -s;
        priority if (a.m == '0) begin
            r = '0;
        end else if (s > 16'sd0) begin
            r = {1'b1, {64{1'b1}}};
        end else if (s == 16'sd0) begin
            r = {1'b0, a.m};
        end else if (s <= -16'sd64) begin
            r = '0;
        end else begin
            r = {1'b0, a.m >> ns[5:0]};
        end
        return r;
    endfunction

    function automatic logic [32:0] wn_clamp(logic [63:0] q);
        logic [32:0] r;
        if (q[63:33] != '0) begin
            r = WN_MAX;
        end else begin
            r = q[32:0];
        end
        return r;
    endfunction

endpackage

### design/planck_band_radiance_core.sv
// Setup turns both band edges into wavenumbers and the temperature into a float; each spectral
// term is then computed (cut off as zero for a large exponent or at zero temperature) and the
// sum is scaled by step and emissivity, every multiply and divide on the shared unit.
// Items do not overlap: start is taken only in idle. At most MAX_STEPS terms; busy stays high until
// the single-cycle result strobe. Reset (i_rst_n low, synchronous) returns to idle and
// loads the default band, step and emissivity. Results cannot be stalled by the receiver.
`include "planck_band_radiance_core_defines.svh"

module planck_band_radiance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [19:0] i_temperature,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [63:0] o_radiance,
    output logic        o_saturated,
    output logic        o_step_limit_hit
);

    // Sequencer states. Every multiply, divide and normalize goes to the shared unit and the
    // sequencer parks in S_WAIT until the unit's done strobe, then resumes
    // at the return state, which consumes the result and issues the next op, if any.
    typedef enum logic [24:0] {
        S_IDLE = 25'h000_0001,
        S_WNS  = 25'h000_0002,
        S_WNE  = 25'h000_0004,
        S_INIT = 25'h000_0008,
        S_LOOP = 25'h000_0010,
        S_VN   = 25'h000_0020,
        S_X1   = 25'h000_0040,
        S_X2   = 25'h000_0080,
        S_V2   = 25'h000_0100,
        S_Y    = 25'h000_0200,
        S_Z    = 25'h000_0400,
        S_SMUL = 25'h000_0800,
        S_SDIV = 25'h000_1000,
        S_P1   = 25'h000_2000,
        S_P2   = 25'h000_4000,
        S_P3   = 25'h000_8000,
        S_Q1   = 25'h001_0000,
        S_Q2   = 25'h002_0000,
        S_P4   = 25'h004_0000,
        S_FIX  = 25'h008_0000,
        S_ACC  = 25'h010_0000,
        S_F1   = 25'h020_0000,
        S_F2   = 25'h040_0000,
        S_F3   = 25'h080_0000,
        S_WAIT = 25'h100_0000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // configuration
    logic [23:0] r_lam_s, n_lam_s;
    logic [23:0] r_lam_e, n_lam_e;
    logic [31:0] r_step, n_step;
    logic [16:0] r_emis, n_emis;

    // per-item working registers
    logic [19:0]                  r_tq, n_tq;
    logic [32:0]                  r_vs, n_vs;
    logic [33:0]                  r_v, n_v;
    pbr_pkg::t_ufl                r_t, n_t;
    pbr_pkg::t_ufl                r_vf, n_vf;
    pbr_pkg::t_ufl                r_v2, n_v2;
    pbr_pkg::t_ufl                r_a, n_a;
    pbr_pkg::t_exp                r_be, n_be;
    logic [30:0]                  r_xq, n_xq;
    logic [63:0]                  r_x, n_x;
    logic [63:0]                  r_term, n_term;
    logic [63:0]                  r_ser, n_ser;
    logic [63:0]                  r_acc, n_acc;
    logic [4:0]                   r_k, n_k;
    logic [6:0]                   r_n, n_n;
    logic                         r_big, n_big;
    logic [pbr_pkg::TERMS_W-1:0]  r_terms, n_terms;
    logic                         r_sat, n_sat;
    logic                         r_lim, n_lim;
    logic [63:0]                  r_hi1, n_hi1;
    logic [63:0]                  r_h2, n_h2;

    // result registers
    logic        r_valid, n_valid;
    logic [63:0] r_radiance, n_radiance;
    logic        r_osat, n_osat;
    logic        r_olim, n_olim;

    pbr_pkg::t_mdu_req w_req;
    pbr_pkg::t_mdu_rsp w_rsp;

    pbr_mdu u_mdu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        pbr_pkg::t_ufl l_f;
        logic [64:0]   l_fx;
        logic [63:0]   l_s;
        logic [64:0]   l_add;
        logic [63:0]   l_top;

        n_state    = r_state;
        n_ret      = r_ret;
        n_lam_s    = r_lam_s;
        n_lam_e    = r_lam_e;
        n_step     = r_step;
        n_emis     = r_emis;
        n_tq       = r_tq;
        n_vs       = r_vs;
        n_v        = r_v;
        n_t        = r_t;
        n_vf       = r_vf;
        n_v2       = r_v2;
        n_a        = r_a;
        n_be       = r_be;
        n_xq       = r_xq;
        n_x        = r_x;
        n_term     = r_term;
        n_ser      = r_ser;
        n_acc      = r_acc;
        n_k        = r_k;
        n_n        = r_n;
        n_big      = r_big;
        n_terms    = r_terms;
        n_sat      = r_sat;
        n_lim      = r_lim;
        n_hi1      = r_hi1;
        n_h2       = r_h2;
        n_valid    = 1'b0;
        n_radiance = r_radiance;
        n_osat     = r_osat;
        n_olim     = r_olim;
        w_req      = '{start: 1'b0, op: pbr_pkg::MDU_MUL, a: '0, b: '0};
        l_f        = '0;
        l_fx       = '0;
        l_s        = '0;
        l_add      = '0;
        l_top      = '0;

        // configuration lands whenever written; the host must write only while idle, the block does not enforce it
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pbr_pkg::CFG_START: n_lam_s = i_cfg_wdata[23:0];
                pbr_pkg::CFG_END:   n_lam_e = i_cfg_wdata[23:0];
                pbr_pkg::CFG_STEP:  n_step  = i_cfg_wdata;
                pbr_pkg::CFG_EMIS:  n_emis  = i_cfg_wdata[16:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // start wavenumber from the start wavelength
                    n_tq    = i_temperature;
                    w_req   = '{1'b1, pbr_pkg::MDU_DIVI, pbr_pkg::WN_NUM, {40'b0, r_lam_s}};
                    n_ret   = S_WNS;
                    n_state = S_WAIT;
                end
            end
            S_WNS: begin
                n_vs    = pbr_pkg::wn_clamp(w_rsp.lo);
                w_req   = '{1'b1, pbr_pkg::MDU_DIVI, pbr_pkg::WN_NUM, {40'b0, r_lam_e}};
                n_ret   = S_WNE;
                n_state = S_WAIT;
            end
            S_WNE: begin
                n_v     = {1'b0, pbr_pkg::wn_clamp(w_rsp.lo)};
                w_req   = '{1'b1, pbr_pkg::MDU_NORM, {44'b0, r_tq}, 64'b0};
                n_ret   = S_INIT;
                n_state = S_WAIT;
            end
            S_INIT: begin
                // temperature as a float, cleared sum and flags
                n_t.m   = w_rsp.lo;
                n_t.e   = -16'sd8 - pbr_pkg::t_exp'({9'b0, w_rsp.cnt});
                n_acc   = '0;
                n_terms = '0;
                n_sat   = 1'b0;
                n_lim   = 1'b0;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                priority if (r_v > {1'b0, r_vs}) begin
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, r_acc, {32'b0, r_step}};
                    n_ret   = S_F1;
                    n_state = S_WAIT;
                end else if (r_terms >= pbr_pkg::TERMS_W'(pbr_pkg::MAX_STEPS)) begin
                    // band not finished: truncate and flag
                    n_lim   = 1'b1;
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, r_acc, {32'b0, r_step}};
                    n_ret   = S_F1;
                    n_state = S_WAIT;
                end else if (r_tq == '0) begin
                    n_term  = '0;
                    n_state = S_ACC;
                end else begin
                    w_req   = '{1'b1, pbr_pkg::MDU_NORM, {30'b0, r_v}, 64'b0};
                    n_ret   = S_VN;
                    n_state = S_WAIT;
                end
            end
            S_VN: begin
                n_vf.m  = w_rsp.lo;
                n_vf.e  = -16'sd16 - pbr_pkg::t_exp'({9'b0, w_rsp.cnt});
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, pbr_pkg::C2_M, w_rsp.lo};
                n_ret   = S_X1;
                n_state = S_WAIT;
            end
            S_X1: begin
                // C2 * nu, then divide by T
                l_f     = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, pbr_pkg::C2_E + r_vf.e);
                n_a     = l_f;
                w_req   = '{1'b1, pbr_pkg::MDU_DIVF, l_f.m, r_t.m};
                n_ret   = S_X2;
                n_state = S_WAIT;
            end
            S_X2: begin
                l_f  = pbr_pkg::fdiv_norm(w_rsp.lo, r_a.e - r_t.e - 16'sd63);
                l_fx = pbr_pkg::fix_q(l_f, 16'sd24);
                if (l_fx[63:0] > {33'b0, pbr_pkg::X_MAX}) begin
                    // exponent beyond 64: term counts as zero
                    n_term  = '0;
                    n_state = S_ACC;
                end else begin
                    n_xq    = l_fx[30:0];
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, r_vf.m, r_vf.m};
                    n_ret   = S_V2;
                    n_state = S_WAIT;
                end
            end
            S_V2: begin
                n_v2 = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, r_vf.e + r_vf.e);
                if (r_xq < pbr_pkg::X_ONE) begin
                    // small x: series for expm1(x)/x
                    n_big   = 1'b0;
                    n_x     = {2'b0, r_xq[23:0], 38'b0};
                    n_term  = pbr_pkg::ONE_Q62;
                    n_ser   = pbr_pkg::ONE_Q62;
                    n_k     = 5'd2;
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, pbr_pkg::ONE_Q62,
                                {2'b0, r_xq[23:0], 38'b0}};
                    n_ret   = S_SMUL;
                    n_state = S_WAIT;
                end else begin
                    n_big   = 1'b1;
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, {33'b0, r_xq}, pbr_pkg::LOG2E};
                    n_ret   = S_Y;
                    n_state = S_WAIT;
                end
            end
            S_Y: begin
                // y = x * log2(e); split into integer n and fraction
                n_n     = w_rsp.lo[62:56];
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, {32'b0, w_rsp.lo[55:24]}, pbr_pkg::LN2};
                n_ret   = S_Z;
                n_state = S_WAIT;
            end
            S_Z: begin
                n_x     = w_rsp.lo;
                n_term  = pbr_pkg::ONE_Q62;
                n_ser   = pbr_pkg::ONE_Q62;
                n_k     = 5'd1;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, pbr_pkg::ONE_Q62, w_rsp.lo};
                n_ret   = S_SMUL;
                n_state = S_WAIT;
            end
            S_SMUL: begin
                w_req   = '{1'b1, pbr_pkg::MDU_DIVI, {w_rsp.hi[61:0], w_rsp.lo[63:62]},
                            {59'b0, r_k}};
                n_ret   = S_SDIV;
                n_state = S_WAIT;
            end
            S_SDIV: begin
                n_term = w_rsp.lo;
                l_s    = r_ser + w_rsp.lo;
                if (r_k == (r_big ? pbr_pkg::SER_LAST_BIG : pbr_pkg::SER_LAST_SMALL)) begin
                    // drop the 1 of exp(x) - 1 where it still shows
                    if (r_big && r_n <= 7'd62) begin
                        l_s = l_s - (64'd1 << (7'd62 - r_n));
                    end
                    n_ser = l_s;
                    if (r_big) begin
                        w_req = '{1'b1, pbr_pkg::MDU_MUL, r_v2.m, r_vf.m};
                        n_ret = S_Q1;
                    end else begin
                        w_req = '{1'b1, pbr_pkg::MDU_DIVF, pbr_pkg::C1_M, pbr_pkg::C2_M};
                        n_ret = S_P1;
                    end
                    n_state = S_WAIT;
                end else begin
                    n_ser   = l_s;
                    n_k     = r_k + 5'd1;
                    w_req   = '{1'b1, pbr_pkg::MDU_MUL, w_rsp.lo, r_x};
                    n_ret   = S_SMUL;
                    n_state = S_WAIT;
                end
            end
            S_P1: begin
                l_f     = pbr_pkg::fdiv_norm(w_rsp.lo, pbr_pkg::C1_E - pbr_pkg::C2_E - 16'sd63);
                n_a     = l_f;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, l_f.m, r_v2.m};
                n_ret   = S_P2;
                n_state = S_WAIT;
            end
            S_P2: begin
                l_f     = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, r_a.e + r_v2.e);
                n_a     = l_f;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, l_f.m, r_t.m};
                n_ret   = S_P3;
                n_state = S_WAIT;
            end
            S_P3: begin
                n_a     = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, r_a.e + r_t.e);
                w_req   = '{1'b1, pbr_pkg::MDU_NORM, r_ser, 64'b0};
                n_ret   = S_P4;
                n_state = S_WAIT;
            end
            S_Q1: begin
                l_f     = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, r_v2.e + r_vf.e);
                n_a     = l_f;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, pbr_pkg::C1_M, l_f.m};
                n_ret   = S_Q2;
                n_state = S_WAIT;
            end
            S_Q2: begin
                n_a     = pbr_pkg::fmul_norm(w_rsp.hi, w_rsp.lo, pbr_pkg::C1_E + r_a.e);
                w_req   = '{1'b1, pbr_pkg::MDU_NORM, r_ser, 64'b0};
                n_ret   = S_P4;
                n_state = S_WAIT;
            end
            S_P4: begin
                // denominator as a float, then numerator / denominator
                n_be    = (r_big ? (pbr_pkg::t_exp'({9'b0, r_n}) - 16'sd62) : -16'sd62)
                          - pbr_pkg::t_exp'({9'b0, w_rsp.cnt});
                w_req   = '{1'b1, pbr_pkg::MDU_DIVF, r_a.m, w_rsp.lo};
                n_ret   = S_FIX;
                n_state = S_WAIT;
            end
            S_FIX: begin
                l_f     = pbr_pkg::fdiv_norm(w_rsp.lo, r_a.e - r_be - 16'sd63);
                l_fx    = pbr_pkg::fix_q(l_f, 16'sd32);
                n_term  = l_fx[63:0];
                n_sat   = r_sat | l_fx[64];
                n_state = S_ACC;
            end
            S_ACC: begin
                // saturating accumulate, advance wavenumber
                l_add = {1'b0, r_acc} + {1'b0, r_term};
                if (l_add[64]) begin
                    n_acc = {64{1'b1}};
                    n_sat = 1'b1;
                end else begin
                    n_acc = l_add[63:0];
                end
                n_terms = r_terms + 1'b1;
                n_v     = r_v + {2'b0, r_step};
                n_state = S_LOOP;
            end
            S_F1: begin
                n_hi1   = w_rsp.hi;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, w_rsp.lo, {47'b0, r_emis}};
                n_ret   = S_F2;
                n_state = S_WAIT;
            end
            S_F2: begin
                n_h2    = w_rsp.hi;
                n_term  = w_rsp.lo;
                w_req   = '{1'b1, pbr_pkg::MDU_MUL, r_hi1, {47'b0, r_emis}};
                n_ret   = S_F3;
                n_state = S_WAIT;
            end
            S_F3: begin
                // drop 40 fraction bits; clamp if anything is left above
                l_top = w_rsp.lo + r_h2;
                if (l_top[63:40] != '0) begin
                    n_radiance = {64{1'b1}};
                    n_osat     = 1'b1;
                end else begin
                    n_radiance = {l_top[39:0], r_term[63:40]};
                    n_osat     = r_sat;
                end
                n_olim  = r_lim;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_valid <= 1'b0;
            r_lam_s <= pbr_pkg::RST_START;
            r_lam_e <= pbr_pkg::RST_END;
            r_step  <= pbr_pkg::RST_STEP;
            r_emis  <= pbr_pkg::RST_EMIS;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_valid <= n_valid;
            r_lam_s <= n_lam_s;
            r_lam_e <= n_lam_e;
            r_step  <= n_step;
            r_emis  <= n_emis;
        end
        r_tq       <= n_tq;
        r_vs       <= n_vs;
        r_v        <= n_v;
        r_t        <= n_t;
        r_vf       <= n_vf;
        r_v2       <= n_v2;
        r_a        <= n_a;
        r_be       <= n_be;
        r_xq       <= n_xq;
        r_x        <= n_x;
        r_term     <= n_term;
        r_ser      <= n_ser;
        r_acc      <= n_acc;
        r_k        <= n_k;
        r_n        <= n_n;
        r_big      <= n_big;
        r_terms    <= n_terms;
        r_sat      <= n_sat;
        r_lim      <= n_lim;
        r_hi1      <= n_hi1;
        r_h2       <= n_h2;
        r_radiance <= n_radiance;
        r_osat     <= n_osat;
        r_olim     <= n_olim;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_radiance       = r_radiance;
    assign o_saturated      = r_osat;
    assign o_step_limit_hit = r_olim;

    // a result strobe comes only with the sequencer back at rest
    `PBR_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result strobe while busy")
    // an accepted start always leaves idle
    `PBR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start transfer did not launch")
    // one strobe per item, never two in a row
    `PBR_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe repeated")

endmodule

### design/pbr_mdu.sv
module pbr_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbr_pkg::t_mdu_req i_req,
    output pbr_pkg::t_mdu_rsp o_rsp
);

    typedef enum logic [3:0] {
        MS_IDLE = 4'b0001,
        MS_MUL  = 4'b0010,
        MS_DIV  = 4'b0100,
        MS_NORM = 4'b1000
    } t_ms;

    t_ms              r_ms, n_ms;
    pbr_pkg::t_mdu_op r_op, n_op;
    logic [63:0]      r_a, n_a;
    logic [63:0]      r_b, n_b;
    logic [127:0]     r_acc, n_acc;
    logic [1:0]       r_ph, n_ph;
    logic [63:0]      r_r, n_r;
    logic [63:0]      r_q, n_q;
    logic [63:0]      r_ds, n_ds;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_done, n_done;

    logic [31:0]  w_ma;
    logic [31:0]  w_mb;
    logic [63:0]  w_prod;
    logic [127:0] w_part;

    // one 32x32 partial product per cycle
    assign w_ma   = r_ph[1] ? r_a[63:32] : r_a[31:0];
    assign w_mb   = r_ph[0] ? r_b[63:32] : r_b[31:0];
    assign w_prod = w_ma * w_mb;

    always_comb begin
        unique case (r_ph)
            2'd0:    w_part = {64'b0, w_prod};
            2'd3:    w_part = {w_prod, 64'b0};
            default: w_part = {32'b0, w_prod, 32'b0};
        endcase
    end

    always_comb begin
        logic        l_q0;
        logic        l_take;
        logic [63:0] l_r2;
        n_ms   = r_ms;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_ph   = r_ph;
        n_r    = r_r;
        n_q    = r_q;
        n_ds   = r_ds;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        l_q0   = 1'b0;
        l_take = 1'b0;
        l_r2   = '0;
        unique case (r_ms)
            MS_IDLE: begin
                if (i_req.start) begin
                    n_op = i_req.op;
                    n_a  = i_req.a;
                    n_b  = i_req.b;
                    unique case (i_req.op)
                        pbr_pkg::MDU_MUL: begin
                            n_acc = '0;
                            n_ph  = 2'd0;
                            n_ms  = MS_MUL;
                        end
                        pbr_pkg::MDU_DIVF: begin
                            l_q0  = (i_req.a >= i_req.b);
                            n_r   = l_q0 ? i_req.a - i_req.b : i_req.a;
                            n_q   = {63'b0, l_q0};
                            n_ds  = '0;
                            n_cnt = 7'd63;
                            n_ms  = MS_DIV;
                        end
                        pbr_pkg::MDU_DIVI: begin
                            n_r   = '0;
                            n_q   = '0;
                            n_ds  = i_req.a;
                            n_cnt = 7'd64;
                            n_ms  = MS_DIV;
                        end
                        pbr_pkg::MDU_NORM: begin
                            n_cnt = '0;
                            n_ms  = MS_NORM;
                        end
                    endcase
                end
            end
            MS_MUL: begin
                n_acc = r_acc + w_part;
                n_ph  = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    n_done = 1'b1;
                    n_ms   = MS_IDLE;
                end
            end
            MS_DIV: begin
                // one quotient bit per cycle, restoring
                l_r2   = {r_r[62:0], r_ds[63]};
                l_take = r_r[63] || (l_r2 >= r_b);
                n_r    = l_take ? l_r2 - r_b : l_r2;
                n_q    = {r_q[62:0], l_take};
                n_ds   = {r_ds[62:0], 1'b0};
                n_cnt  = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_done = 1'b1;
                    n_ms   = MS_IDLE;
                end
            end
            MS_NORM: begin
                priority if (r_a == '0 || r_a[63]) begin
                    n_done = 1'b1;
                    n_ms   = MS_IDLE;
                end else if (r_a[63:56] == '0) begin
                    n_a   = {r_a[55:0], 8'b0};
                    n_cnt = r_cnt + 7'd8;
                end else begin
                    n_a   = {r_a[62:0], 1'b0};
                    n_cnt = r_cnt + 7'd1;
                end
            end
            default: n_ms = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms   <= MS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ms   <= n_ms;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_ph  <= n_ph;
        r_r   <= n_r;
        r_q   <= n_q;
        r_ds  <= n_ds;
        r_cnt <= n_cnt;
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.hi   = r_acc[127:64];
        o_rsp.cnt  = r_cnt;
        unique case (r_op)
            pbr_pkg::MDU_MUL:  o_rsp.lo = r_acc[63:0];
            pbr_pkg::MDU_NORM: o_rsp.lo = r_a;
            default:           o_rsp.lo = r_q;
        endcase
    end

endmodule

### tb/planck_band_radiance_core_tb.sv
`timescale 1ns / 1ps

module planck_band_radiance_core_tb;

    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam logic [32:0] WN_TOP      = 33'h1_FFFF_FFFF;
    localparam logic [63:0] C2_RAW      = 64'd6179448269;
    localparam logic [63:0] C1_RAW      = 64'd14743262263000000000;
    localparam logic [63:0] LOG2E_RAW   = 64'd6196328019;
    localparam logic [63:0] LN2_RAW     = 64'd744261118;
    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] XQ_ONE      = 64'h100_0000;
    localparam logic [63:0] XQ_MAX      = 64'h4000_0000;

    typedef struct {
        logic [63:0] m;
        int          e;
    } t_flt;

    typedef struct {
        logic [63:0] radiance;
        logic        saturated;
        logic        limit_hit;
    } t_band_result;

    // Predicts band radiance for each accepted temperature and holds the expected results.
    class radiance_board;
        logic [23:0]  lam_start;
        logic [23:0]  lam_end;
        logic [31:0]  step;
        logic [16:0]  emis;
        t_band_result awaited[$];
        int           errors;

        function new();
            lam_start = 24'd524288;
            lam_end   = 24'd917504;
            step      = 32'd65536;
            emis      = 17'd65536;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                pbr_pkg::CFG_START: lam_start = val[23:0];
                pbr_pkg::CFG_END:   lam_end   = val[23:0];
                pbr_pkg::CFG_STEP:  step      = val;
                default:            emis      = val[16:0];
            endcase
        endfunction

        function logic [63:0] wavenumber(logic [23:0] lam);
            logic [63:0] w;
            if (lam == 0) return {31'd0, WN_TOP};
            w = 64'd42949672960000 / {40'd0, lam};
            return (w > {31'd0, WN_TOP}) ? {31'd0, WN_TOP} : w;
        endfunction

        function t_flt fnorm(logic [63:0] m, int e);
            t_flt r;
            r.m = 0;
            r.e = 0;
            if (m == 0) return r;
            while (!m[63]) begin
                m = m << 1;
                e--;
            end
            r.m = m;
            r.e = e;
            return r;
        endfunction

        function t_flt fmul(t_flt a, t_flt b);
            logic [127:0] p;
            if (a.m == 0 || b.m == 0) return fnorm(0, 0);
            p = {64'd0, a.m} * {64'd0, b.m};
            if (p[127]) return fnorm(p[127:64], a.e + b.e + 64);
            return fnorm(p[126:63], a.e + b.e + 63);
        endfunction

        function t_flt fdiv(t_flt a, t_flt b);
            logic [126:0] q;
            if (a.m == 0 || b.m == 0) return fnorm(0, 0);
            q = {a.m, 63'd0} / {63'd0, b.m};
            return fnorm(q[63:0], a.e - b.e - 63);
        endfunction

        function logic [63:0] to_fixed(t_flt a, int frac, inout logic ovf);
            int s;
            s = a.e + frac;
            if (a.m == 0) return 0;
            if (s > 0) begin
                ovf = 1'b1;
                return '1;
            end
            if (s == 0) return a.m;
            if (s <= -64) return 0;
            return a.m >> (-s);
        endfunction

        function logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        // One Planck spectral term, Q32.32
        function logic [63:0] planck_term(logic [63:0] vq, logic [63:0] tq, inout logic sat);
            t_flt        v, t, c2, c1, b, v2;
            logic [63:0] xq, s, term, x62, y, z;
            logic        junk;
            int          n;
            junk = 1'b0;
            if (tq == 0) return 0;
            v  = fnorm(vq, -16);
            t  = fnorm(tq, -8);
            c2 = fnorm(C2_RAW, -32);
            c1 = fnorm(C1_RAW, -90);
            xq = to_fixed(fdiv(fmul(c2, v), t), 24, junk);
            if (xq > XQ_MAX) return 0;
            v2 = fmul(v, v);
            s = Q62_ONE;
            term = Q62_ONE;
            if (xq < XQ_ONE) begin
                // expm1(x)/x series
                x62 = xq << 38;
                for (int k = 2; k <= 21; k++) begin
                    term = mul_q62(term, x62) / k;
                    s += term;
                end
                b = fdiv(fmul(fmul(fdiv(c1, c2), v2), t), fnorm(s, -62));
            end else begin
                y = (xq * LOG2E_RAW) >> 24;
                n = int'(y >> 32);
                z = (y & 64'hFFFF_FFFF) * LN2_RAW;
                for (int k = 1; k <= 20; k++) begin
                    term = mul_q62(term, z) / k;
                    s += term;
                end
                if (n <= 62) s -= (64'd1 << (62 - n));
                b = fdiv(fmul(c1, fmul(v2, v)), fnorm(s, n - 62));
            end
            return to_fixed(b, 32, sat);
        endfunction

        function void note_transfer(logic [19:0] temp);
            logic [63:0]  vs, v, acc, b, top;
            logic [127:0] p1, p2;
            int           done;
            t_band_result r;
            r.saturated = 1'b0;
            r.limit_hit = 1'b0;
            vs   = wavenumber(lam_start);
            v    = wavenumber(lam_end);
            acc  = 0;
            done = 0;
            while (v <= vs) begin
                if (done >= pbr_pkg::MAX_STEPS) begin
                    r.limit_hit = 1'b1;
                    break;
                end
                b = planck_term(v, {44'd0, temp}, r.saturated);
                if (acc > ~b) begin
                    acc = '1;
                    r.saturated = 1'b1;
                end else begin
                    acc += b;
                end
                done++;
                v += {32'd0, step};
            end
            p1  = {64'd0, acc} * {96'd0, step};
            p2  = {64'd0, p1[63:0]} * {111'd0, emis};
            top = p1[127:64] * {47'd0, emis} + p2[127:64];
            if (top[63:40] != 0) begin
                r.radiance  = '1;
                r.saturated = 1'b1;
            end else begin
                r.radiance = {top[39:0], p2[63:40]};
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [63:0] rad, logic sat, logic lim);
            t_band_result x;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result radiance=%h", rad);
                return;
            end
            x = awaited.pop_front();
            if (x.radiance !== rad || x.saturated !== sat || x.limit_hit !== lim) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h sat=%b lim=%b, got %h sat=%b lim=%b",
                             x.radiance, x.saturated, x.limit_hit, rad, sat, lim);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [19:0] i_temperature;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        o_valid;
    logic [63:0] o_radiance;
    logic        o_saturated;
    logic        o_step_limit_hit;

    radiance_board board = new();
    logic          idle_on;
    int            cycles = 0;

    planck_band_radiance_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_temperature    (i_temperature),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_radiance       (o_radiance),
        .o_saturated      (o_saturated),
        .o_step_limit_hit (o_step_limit_hit)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Check every result in the cycle its strobe is up; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_radiance, o_saturated, o_step_limit_hit);
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold start until the block takes the temperature, then, with idling on, maybe drop it before the next one.
    task automatic send_temp(logic [19:0] temp);
        start         <= 1'b1;
        i_temperature <= temp;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_transfer(temp);
        if (idle_on && $urandom_range(0, 1) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Drain all outstanding results, then let the block settle to idle.
    task automatic drain;
        start <= 1'b0;
        while (board.awaited.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic set_band(logic [23:0] ls, logic [23:0] le, logic [31:0] st,
                            logic [16:0] em);
        logic [31:0] vals [4];
        vals[0] = {8'd0, ls};
        vals[1] = {8'd0, le};
        vals[2] = st;
        vals[3] = {15'd0, em};
        for (int i = 0; i < 4; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= 2'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            board.set_reg(2'(i), vals[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Pick a band of at most four terms; now and then an empty one.
    task automatic random_band;
        logic [23:0] ls, le;
        logic [63:0] vs, ve, d;
        logic [31:0] st;
        ls = 24'($urandom_range(6554, 16777215));
        if ($urandom_range(0, 7) == 0) begin
            le = 24'($urandom_range(6554, ls));
        end else begin
            le = ls + 24'($urandom_range(0, ls / 8));
            if (le < ls) le = ls;
        end
        vs = board.wavenumber(ls);
        ve = board.wavenumber(le);
        d  = (vs >= ve) ? vs - ve : 0;
        if ($urandom_range(0, 3) == 0 && d < 64'h8000_0000) begin
            st = $urandom | 32'h8000_0000;
        end else begin
            st = 32'(d / $urandom_range(1, 4) + 1);
        end
        set_band(ls, le, st, 17'($urandom_range(0, 131071)));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_temperature <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        idle_on       = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short two-term band near 8 um: temperature extremes, zero temperature.
        set_band(24'd524288, 24'd540672, 32'd1638400, 17'd65536);
        send_temp(20'd1);
        send_temp(20'd0);
        send_temp(20'd300 << 8);
        send_temp(20'hFFFFF);
        send_temp(20'd6000 << 8);
        drain();

        // Empty band: end wavelength shorter than start.
        set_band(24'd917504, 24'd524288, 32'd65536, 17'd65536);
        send_temp(20'd1000 << 8);
        drain();

        // Zero step never advances: the step limit cuts the sum.
        set_band(24'd524288, 24'd524288, 32'd0, 17'd65536);
        send_temp(20'd1);
        drain();

        // Shortest wavelength, widest step, emissivity above one.
        set_band(24'd6554, 24'd6554, 32'hFFFF_FFFF, 17'd131071);
        send_temp(20'hFFFFF);
        send_temp(20'd1000 << 8);
        send_temp(20'd50 << 8);
        drain();

        // Longest wavelength gives the small-exponent series at high temperature.
        set_band(24'hFFFFFF, 24'hFFFFFF, 32'd65536, 17'd0);
        send_temp(20'hFFFFF);
        drain();
        set_band(24'hFFFFFF, 24'hFFFFFF, 32'd1, 17'd65536);
        send_temp(20'hFFFFF);
        send_temp(20'd2000 << 8);
        drain();

        // Zero wavelength saturates the wavenumber.
        set_band(24'd0, 24'd0, 32'd65536, 17'd65536);
        send_temp(20'hFFFFF);
        send_temp(20'd3);
        drain();

        // Random bands, seven temperatures each; the last band runs without idling.
        for (int ph = 0; ph < 20; ph++) begin
            random_band();
            if (ph == 19) idle_on = 1'b0;
            for (int i = 0; i < 7; i++) begin
                if ($urandom_range(0, 9) == 0) send_temp(20'($urandom_range(1, 64)));
                else send_temp(20'($urandom));
            end
            drain();
        end

        board.errors += board.awaited.size();
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
